/* sv/hsvrgb_pkg.sv */
package hsvrgb_pkg;

   // Field widths of one input beat and one result beat.
   localparam int HueW   = 16;
   localparam int SatW   = 14;
   localparam int ValW   = 14;
   localparam int ChanW  = 8;
   localparam int ReqW   = 48;   // 44 field bits filled up to whole bytes
   localparam int RspW   = 24;

   // Unit fixed point: 4096 means 1.0, so a clamped level needs 13 bits.
   localparam int UnitW  = 13;
   localparam logic [UnitW-1:0] UnitOne = 13'd4096;

   // Scale is One * 60. A level is val * (Scale - sat*k) * 17 >> 26, which is
   // the same as val * (Scale - sat*k) * 255 / (One * Scale) because
   // One * Scale = 15 * 2^26.
   localparam int ScaleW  = 18;
   localparam logic [ScaleW:0] Scale = 19'd245760;
   localparam int KW      = 6;
   localparam int ProdW   = UnitW + ScaleW;
   localparam int LevelLsb = 26;

   // Hue reduction: bias into a positive range that keeps the value mod 360,
   // then divide by 360 through a reciprocal that is exact below 2^17.
   localparam int BiasW      = 17;
   localparam logic [BiasW-1:0] HueBias = 17'd33120;   // 92 * 360
   localparam logic [BiasW-1:0] HueRecip = 17'd93207;  // ceil(2^25 / 360)
   localparam int RecipShift = 25;
   localparam int QuotW      = 8;
   localparam int HueModW    = 9;
   localparam logic [HueModW-1:0] FullTurn = 9'd360;
   localparam logic [HueModW-1:0] SectorSpan = 9'd60;
   localparam logic [KW-1:0] SectorK = 6'd60;

   // Color wheel sectors, 60 degrees each.
   localparam logic [2:0] SEC_RY = 3'd0;   // red to yellow
   localparam logic [2:0] SEC_YG = 3'd1;   // yellow to green
   localparam logic [2:0] SEC_GC = 3'd2;   // green to cyan
   localparam logic [2:0] SEC_CB = 3'd3;   // cyan to blue
   localparam logic [2:0] SEC_BM = 3'd4;   // blue to magenta
   localparam logic [2:0] SEC_MR = 3'd5;   // magenta to red

endpackage

/* sv/hsvrgb_level.sv */
// One channel level: two register stages, then the final scale.
module hsvrgb_level (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [hsvrgb_pkg::UnitW-1:0]   sat,
   input  logic [hsvrgb_pkg::UnitW-1:0]   val,
   input  logic [hsvrgb_pkg::KW-1:0]      k,
   output logic [hsvrgb_pkg::ChanW-1:0]   level
);

   logic [hsvrgb_pkg::ScaleW:0]     sk_in;
   logic [hsvrgb_pkg::ScaleW-1:0]   m_in;
   logic [hsvrgb_pkg::ScaleW-1:0]   m_ff;
   logic [hsvrgb_pkg::UnitW-1:0]    val_ff;
   logic [hsvrgb_pkg::ProdW-1:0]    prod_in;
   logic [hsvrgb_pkg::ProdW-1:0]    prod_ff;
   logic [hsvrgb_pkg::ProdW+4:0]    scaled;

   // sat*k never exceeds Scale, so the difference fits in ScaleW bits.
   assign sk_in   = (hsvrgb_pkg::ScaleW+1)'(sat) * (hsvrgb_pkg::ScaleW+1)'(k);
   assign m_in    = hsvrgb_pkg::ScaleW'(hsvrgb_pkg::Scale - sk_in);
   assign prod_in = hsvrgb_pkg::ProdW'(val_ff) * hsvrgb_pkg::ProdW'(m_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff    <= m_in;
         val_ff  <= val;
         prod_ff <= prod_in;
      end
   end

   // Times 17 as shift and add; the top level is at most 255.
   assign scaled = {prod_ff, 4'b0000} + (hsvrgb_pkg::ProdW+5)'(prod_ff);
   assign level  = scaled[hsvrgb_pkg::LevelLsb +: hsvrgb_pkg::ChanW];

endmodule

/* sv/hsv_to_rgb_converter.sv */
// Channel  Dir  Beat contents (tdata, lowest bits first)
// req_*    in   hue_degrees[15:0], saturation[29:16], brightness[43:30], zero pad
// rsp_*    out  red[7:0], green[15:8], blue[23:16]
//
// One beat enters per clock unless the output is stalled.
// Stages: clamp and hue reciprocal multiply, hue remainder and sector,
// per-channel sat*k, per-channel val product, output register.
// The whole pipeline advances together whenever the output register is
// empty or its beat is being taken; a stalled output holds every stage.
// Synchronous reset clears the valid bits only.
module hsv_to_rgb_converter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // hue_degrees[15:0], saturation[29:16], brightness[43:30], pad[47:44]
   input  logic [hsvrgb_pkg::ReqW-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [hsvrgb_pkg::RspW-1:0]   rsp_tdata
);

   logic                                 adv;
   logic                                 s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic                                 rsp_tvalid_ff;
   logic [hsvrgb_pkg::RspW-1:0]          rsp_tdata_ff;
   logic [hsvrgb_pkg::RspW-1:0]          rsp_tdata_in;

   logic signed [hsvrgb_pkg::HueW-1:0]   req_hue;
   logic signed [hsvrgb_pkg::SatW-1:0]   req_sat;
   logic signed [hsvrgb_pkg::ValW-1:0]   req_val;
   logic [hsvrgb_pkg::UnitW-1:0]         sat_in, val_in;
   logic [hsvrgb_pkg::BiasW-1:0]         biased_in;
   logic [2*hsvrgb_pkg::BiasW-1:0]       recip_prod;

   logic [hsvrgb_pkg::BiasW-1:0]         s1_biased_ff;
   logic [hsvrgb_pkg::QuotW-1:0]         s1_quot_ff;
   logic [hsvrgb_pkg::UnitW-1:0]         s1_sat_ff, s1_val_ff;

   logic [hsvrgb_pkg::BiasW-1:0]         hue_mod_wide;
   logic [hsvrgb_pkg::HueModW-1:0]       hue_mod_in;
   logic [2:0]                           sec_in;
   logic [hsvrgb_pkg::HueModW-1:0]       rem_wide;

   logic [2:0]                           s2_sec_ff, s3_sec_ff, s4_sec_ff;
   logic [hsvrgb_pkg::KW-1:0]            s2_rem_ff;
   logic [hsvrgb_pkg::UnitW-1:0]         s2_sat_ff, s2_val_ff;
   logic [hsvrgb_pkg::KW-1:0]            k_t;

   logic [hsvrgb_pkg::ChanW-1:0]         lv_v, lv_p, lv_q, lv_t;
   logic [hsvrgb_pkg::ChanW-1:0]         red, green, blue;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign req_hue = req_tdata[15:0];
   assign req_sat = req_tdata[29:16];
   assign req_val = req_tdata[43:30];

   // Stage 1: clamp to 0..1.0 and start the divide by 360.
   always_comb begin
      if (req_sat[hsvrgb_pkg::SatW-1]) begin
         sat_in = '0;
      end else if (req_sat[hsvrgb_pkg::UnitW-1:0] > hsvrgb_pkg::UnitOne) begin
         sat_in = hsvrgb_pkg::UnitOne;
      end else begin
         sat_in = req_sat[hsvrgb_pkg::UnitW-1:0];
      end
      if (req_val[hsvrgb_pkg::ValW-1]) begin
         val_in = '0;
      end else if (req_val[hsvrgb_pkg::UnitW-1:0] > hsvrgb_pkg::UnitOne) begin
         val_in = hsvrgb_pkg::UnitOne;
      end else begin
         val_in = req_val[hsvrgb_pkg::UnitW-1:0];
      end
   end

   assign biased_in  = hsvrgb_pkg::BiasW'(req_hue) + hsvrgb_pkg::HueBias;
   assign recip_prod = (2*hsvrgb_pkg::BiasW)'(biased_in) *
                       (2*hsvrgb_pkg::BiasW)'(hsvrgb_pkg::HueRecip);

   // Stage 2: remainder mod 360, then sector and offset within it.
   assign hue_mod_wide = s1_biased_ff -
                         hsvrgb_pkg::BiasW'(s1_quot_ff) *
                         hsvrgb_pkg::BiasW'(hsvrgb_pkg::FullTurn);
   assign hue_mod_in   = hue_mod_wide[hsvrgb_pkg::HueModW-1:0];

   always_comb begin
      if (hue_mod_in >= 9'd300) begin
         sec_in = hsvrgb_pkg::SEC_MR;
      end else if (hue_mod_in >= 9'd240) begin
         sec_in = hsvrgb_pkg::SEC_BM;
      end else if (hue_mod_in >= 9'd180) begin
         sec_in = hsvrgb_pkg::SEC_CB;
      end else if (hue_mod_in >= 9'd120) begin
         sec_in = hsvrgb_pkg::SEC_GC;
      end else if (hue_mod_in >= 9'd60) begin
         sec_in = hsvrgb_pkg::SEC_YG;
      end else begin
         sec_in = hsvrgb_pkg::SEC_RY;
      end
   end

   assign rem_wide = hue_mod_in - hsvrgb_pkg::HueModW'(sec_in) * hsvrgb_pkg::SectorSpan;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         s4_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff     <= req_tvalid;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         s4_vld_ff     <= s3_vld_ff;
         rsp_tvalid_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_biased_ff <= biased_in;
         s1_quot_ff   <= recip_prod[hsvrgb_pkg::RecipShift +: hsvrgb_pkg::QuotW];
         s1_sat_ff    <= sat_in;
         s1_val_ff    <= val_in;
         s2_sec_ff    <= sec_in;
         s2_rem_ff    <= rem_wide[hsvrgb_pkg::KW-1:0];
         s2_sat_ff    <= s1_sat_ff;
         s2_val_ff    <= s1_val_ff;
         s3_sec_ff    <= s2_sec_ff;
         s4_sec_ff    <= s3_sec_ff;
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // Stages 3 and 4: one lane per level.
   assign k_t = hsvrgb_pkg::SectorK - s2_rem_ff;

   hsvrgb_level u_lv_v (
      .clock(clock), .enable(adv), .sat(s2_sat_ff), .val(s2_val_ff),
      .k('0), .level(lv_v)
   );
   hsvrgb_level u_lv_p (
      .clock(clock), .enable(adv), .sat(s2_sat_ff), .val(s2_val_ff),
      .k(hsvrgb_pkg::SectorK), .level(lv_p)
   );
   hsvrgb_level u_lv_q (
      .clock(clock), .enable(adv), .sat(s2_sat_ff), .val(s2_val_ff),
      .k(s2_rem_ff), .level(lv_q)
   );
   hsvrgb_level u_lv_t (
      .clock(clock), .enable(adv), .sat(s2_sat_ff), .val(s2_val_ff),
      .k(k_t), .level(lv_t)
   );

   // Stage 5: place the levels by sector.
   always_comb begin
      case (s4_sec_ff)
         hsvrgb_pkg::SEC_YG: begin
            red = lv_q; green = lv_v; blue = lv_p;
         end
         hsvrgb_pkg::SEC_GC: begin
            red = lv_p; green = lv_v; blue = lv_t;
         end
         hsvrgb_pkg::SEC_CB: begin
            red = lv_p; green = lv_q; blue = lv_v;
         end
         hsvrgb_pkg::SEC_BM: begin
            red = lv_t; green = lv_p; blue = lv_v;
         end
         hsvrgb_pkg::SEC_MR: begin
            red = lv_v; green = lv_p; blue = lv_q;
         end
         default: begin
            red = lv_v; green = lv_t; blue = lv_p;
         end
      endcase
      rsp_tdata_in = {blue, green, red};
   end

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while the output beat is stalled");

   a_hue_reduced: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> hue_mod_in < hsvrgb_pkg::FullTurn)
      else $error("hue remainder out of range");

   a_sector_rem: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (s2_sec_ff <= hsvrgb_pkg::SEC_MR) &&
                    (s2_rem_ff < hsvrgb_pkg::SectorK))
      else $error("sector or offset out of range");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && !s4_vld_ff)
      else $error("pipeline holds a beat right after reset");

endmodule
